### rtl/kwmc_pkg.sv
package kwmc_pkg;

  localparam int KEY_BITS   = 62;
  localparam int IDX_BITS   = 12;
  localparam int DIST_BITS  = 13;
  localparam int RCNT_BITS  = 32;
  localparam int KLEN_BITS  = 5;

  // opcodes of an input item
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BASE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_COUNT = 2'd3;

  // load status codes
  localparam logic [1:0] LS_INSERTED  = 2'd0;
  localparam logic [1:0] LS_DUPLICATE = 2'd1;
  localparam logic [1:0] LS_FULL      = 2'd2;

  // base letters
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KEY_BITS-1:0] library_code;
    logic [7:0]          base_char;
    logic [IDX_BITS-1:0] query_index;
  } in_item_t;

  typedef struct packed {
    logic                 window_valid;
    logic                 hit;
    logic                 first_in_record;
    logic [IDX_BITS-1:0]  match_index;
    logic [1:0]           load_status;
    logic [DIST_BITS-1:0] distinct_hits;
    logic [RCNT_BITS-1:0] record_count;
  } out_item_t;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_LOOKUP,
    CMD_SKIP,
    CMD_END,
    CMD_COUNT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [KEY_BITS-1:0] key;
    logic [IDX_BITS-1:0] qidx;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_UPD,
    BS_CNT,
    BS_CLR
  } back_state_t;

endpackage

### rtl/kwmc_queue.sv
module kwmc_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);

  T           mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // advance pointers and fill count
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

### rtl/kwmc_front.sv
module kwmc_front #(
  parameter int MAX_KMER = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [kwmc_pkg::KLEN_BITS-1:0] cfg_data,
  input  logic                         accept,
  input  kwmc_pkg::in_item_t           item,
  output kwmc_pkg::cmd_t               cmd
);

  logic [kwmc_pkg::KLEN_BITS-1:0] klen_r;
  logic [kwmc_pkg::KLEN_BITS-1:0] k_eff;
  logic [kwmc_pkg::KEY_BITS-1:0]  mask;
  logic [kwmc_pkg::KEY_BITS-1:0]  win_r, win_nxt;
  logic [kwmc_pkg::KLEN_BITS-1:0] run_r, run_nxt;
  logic [1:0]                     code;
  logic                           code_ok;

  // clamp window length
  always_comb begin
    if (klen_r == '0) k_eff = kwmc_pkg::KLEN_BITS'(1);
    else if (klen_r > kwmc_pkg::KLEN_BITS'(MAX_KMER)) k_eff = kwmc_pkg::KLEN_BITS'(MAX_KMER);
    else k_eff = klen_r;
  end

  // key mask of 2k bits
  always_comb begin
    for (int b = 0; b < kwmc_pkg::KEY_BITS; b++) begin
      mask[b] = (b < 2 * int'(k_eff));
    end
  end

  // decode base letter
  always_comb begin
    code    = 2'd0;
    code_ok = 1'b1;
    unique case (item.base_char)
      kwmc_pkg::CH_A_UP, kwmc_pkg::CH_A_LO: code = 2'd0;
      kwmc_pkg::CH_C_UP, kwmc_pkg::CH_C_LO: code = 2'd1;
      kwmc_pkg::CH_G_UP, kwmc_pkg::CH_G_LO: code = 2'd2;
      kwmc_pkg::CH_T_UP, kwmc_pkg::CH_T_LO: code = 2'd3;
      default: code_ok = 1'b0;
    endcase
  end

  // classify item and roll window
  always_comb begin
    win_nxt  = win_r;
    run_nxt  = run_r;
    cmd.op   = kwmc_pkg::CMD_SKIP;
    cmd.key  = item.library_code & mask;
    cmd.qidx = item.query_index;
    unique case (item.opcode)
      kwmc_pkg::OP_LOAD: cmd.op = kwmc_pkg::CMD_LOAD;
      kwmc_pkg::OP_BASE: begin
        if (code_ok) begin
          win_nxt = {win_r[kwmc_pkg::KEY_BITS-3:0], code};
          if (run_r < k_eff) run_nxt = run_r + kwmc_pkg::KLEN_BITS'(1);
        end else begin
          run_nxt = '0;
        end
        win_nxt = win_nxt & mask;
        cmd.key = win_nxt;
        if (code_ok && run_nxt >= k_eff) cmd.op = kwmc_pkg::CMD_LOOKUP;
      end
      kwmc_pkg::OP_END: begin
        cmd.op  = kwmc_pkg::CMD_END;
        win_nxt = '0;
        run_nxt = '0;
      end
      default: cmd.op = kwmc_pkg::CMD_COUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= kwmc_pkg::KLEN_BITS'(31);
      win_r  <= '0;
      run_r  <= '0;
    end else begin
      if (cfg_valid) klen_r <= cfg_data;
      if (accept) begin
        win_r <= win_nxt;
        run_r <= run_nxt;
      end
    end
  end

endmodule

### rtl/kwmc_back.sv
module kwmc_back #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int COUNT_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  kwmc_pkg::cmd_t      cmd_in,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output kwmc_pkg::out_item_t res
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW = (NW > kwmc_pkg::IDX_BITS) ? NW : kwmc_pkg::IDX_BITS;

  logic [kwmc_pkg::KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]         cnt_mem [TABLE_ENTRIES];
  logic                          seen_mem [TABLE_ENTRIES];

  kwmc_pkg::back_state_t          state_r, state_nxt;
  kwmc_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [NW-1:0]                  n_r, n_nxt;
  logic [NW-1:0]                  iss_r, iss_nxt;
  logic [kwmc_pkg::DIST_BITS-1:0] dist_r, dist_nxt;
  logic                           kv_r, kv_nxt;
  logic [IW-1:0]                  kidx_r;
  logic [IW-1:0]                  hidx_r, hidx_nxt;
  logic [kwmc_pkg::KEY_BITS-1:0]  kdat_r;
  logic [COUNT_BITS-1:0]          cnt_q_r;
  logic                           seen_q_r;

  logic                           k_re;
  logic                           k_we;
  logic [IW-1:0]                  k_wa;
  logic                           c_re;
  logic [IW-1:0]                  c_ra;
  logic                           c_we;
  logic [IW-1:0]                  c_wa;
  logic [COUNT_BITS-1:0]          c_wd;
  logic                           s_we;
  logic [IW-1:0]                  s_wa;
  logic                           s_wd;
  logic                           match, miss;
  logic [CW-1:0]                  q_ext;

  assign q_ext = CW'(cmd_in.qidx);
  assign match = kv_r && (kdat_r == cmd_r.key);
  assign miss  = !match && !kv_r && (iss_r >= n_r);

  // sequence one command at a time
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    n_nxt     = n_r;
    iss_nxt   = iss_r;
    dist_nxt  = dist_r;
    hidx_nxt  = hidx_r;
    kv_nxt    = 1'b0;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    k_re      = 1'b0;
    k_we      = 1'b0;
    k_wa      = n_r[IW-1:0];
    c_re      = 1'b0;
    c_ra      = hidx_r;
    c_we      = 1'b0;
    c_wa      = n_r[IW-1:0];
    c_wd      = '0;
    s_we      = 1'b0;
    s_wa      = n_r[IW-1:0];
    s_wd      = 1'b0;
    unique case (state_r)
      kwmc_pkg::BS_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_in;
          unique case (cmd_in.op)
            kwmc_pkg::CMD_LOAD, kwmc_pkg::CMD_LOOKUP: begin
              iss_nxt   = '0;
              state_nxt = kwmc_pkg::BS_SCAN;
            end
            kwmc_pkg::CMD_END: begin
              res_push          = 1'b1;
              res.distinct_hits = dist_r;
              dist_nxt          = '0;
              iss_nxt           = '0;
              state_nxt         = kwmc_pkg::BS_CLR;
            end
            kwmc_pkg::CMD_COUNT: begin
              if (q_ext < CW'(n_r)) begin
                c_re      = 1'b1;
                c_ra      = q_ext[IW-1:0];
                state_nxt = kwmc_pkg::BS_CNT;
              end else begin
                res_push = 1'b1;
              end
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      kwmc_pkg::BS_SCAN: begin
        // issue next key read, compare the previous one
        if (iss_r < n_r) begin
          k_re    = 1'b1;
          kv_nxt  = 1'b1;
          iss_nxt = iss_r + NW'(1);
        end
        if (match) begin
          kv_nxt = 1'b0;
          if (cmd_r.op == kwmc_pkg::CMD_LOAD) begin
            res_push        = 1'b1;
            res.match_index = kwmc_pkg::IDX_BITS'(kidx_r);
            res.load_status = kwmc_pkg::LS_DUPLICATE;
            state_nxt       = kwmc_pkg::BS_IDLE;
          end else begin
            c_re      = 1'b1;
            c_ra      = kidx_r;
            hidx_nxt  = kidx_r;
            state_nxt = kwmc_pkg::BS_UPD;
          end
        end else if (miss) begin
          res_push  = 1'b1;
          state_nxt = kwmc_pkg::BS_IDLE;
          if (cmd_r.op == kwmc_pkg::CMD_LOAD) begin
            if (n_r == NW'(TABLE_ENTRIES)) begin
              res.load_status = kwmc_pkg::LS_FULL;
            end else begin
              k_we            = 1'b1;
              c_we            = 1'b1;
              s_we            = 1'b1;
              res.match_index = kwmc_pkg::IDX_BITS'(n_r);
              res.load_status = kwmc_pkg::LS_INSERTED;
              n_nxt           = n_r + NW'(1);
            end
          end else begin
            res.window_valid = 1'b1;
          end
        end
      end
      kwmc_pkg::BS_UPD: begin
        res_push         = 1'b1;
        res.window_valid = 1'b1;
        res.hit          = 1'b1;
        res.match_index  = kwmc_pkg::IDX_BITS'(hidx_r);
        if (!seen_q_r) begin
          res.first_in_record = 1'b1;
          s_we = 1'b1;
          s_wa = hidx_r;
          s_wd = 1'b1;
          c_we = 1'b1;
          c_wa = hidx_r;
          c_wd = (&cnt_q_r) ? cnt_q_r : cnt_q_r + COUNT_BITS'(1);
          if (!(&dist_r)) dist_nxt = dist_r + kwmc_pkg::DIST_BITS'(1);
        end
        state_nxt = kwmc_pkg::BS_IDLE;
      end
      kwmc_pkg::BS_CNT: begin
        res_push         = 1'b1;
        res.record_count = kwmc_pkg::RCNT_BITS'(cnt_q_r);
        state_nxt        = kwmc_pkg::BS_IDLE;
      end
      kwmc_pkg::BS_CLR: begin
        // sweep seen marks of loaded entries
        if (iss_r < n_r) begin
          s_we    = 1'b1;
          s_wa    = iss_r[IW-1:0];
          iss_nxt = iss_r + NW'(1);
        end else begin
          state_nxt = kwmc_pkg::BS_IDLE;
        end
      end
      default: state_nxt = kwmc_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwmc_pkg::BS_IDLE;
      n_r     <= '0;
      dist_r  <= '0;
      iss_r   <= '0;
      kv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      dist_r  <= dist_nxt;
      iss_r   <= iss_nxt;
      kv_r    <= kv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    hidx_r <= hidx_nxt;
    kidx_r <= iss_r[IW-1:0];
  end

  // key store
  always_ff @(posedge clk) begin
    if (k_we) key_mem[k_wa] <= cmd_r.key;
    if (k_re) kdat_r <= key_mem[iss_r[IW-1:0]];
  end

  // record count store
  always_ff @(posedge clk) begin
    if (c_we) cnt_mem[c_wa] <= c_wd;
    if (c_re) cnt_q_r <= cnt_mem[c_ra];
  end

  // seen mark store, read alongside the count
  always_ff @(posedge clk) begin
    if (s_we) seen_mem[s_wa] <= s_wd;
    if (c_re) seen_q_r <= seen_mem[c_ra];
  end

endmodule

### rtl/kmer_window_match_counter.sv
// Channel   Handshake                 Payload
// in_       in_push / in_full         in_item  (kwmc_pkg::in_item_t)
// out_      out_pop / out_empty       out_item (kwmc_pkg::out_item_t)
// cfg_      cfg_valid / cfg_ready     cfg_data (kmer_length, 5 bits)
//
// Lookups and loads scan the loaded keys one per cycle through the single read port
// of the key store.
// End of record sweeps the seen marks of the loaded entries.
// Reset is synchronous; no clearing pass is needed, new entries are zeroed on insert.
// A two-entry command queue lets the window logic keep taking items while the back stalls.
module kmer_window_match_counter #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_KMER      = 31,
  parameter int COUNT_BITS    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  kwmc_pkg::in_item_t             in_item,
  output logic                           out_empty,
  input  logic                           out_pop,
  output kwmc_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kwmc_pkg::KLEN_BITS-1:0] cfg_data
);

  kwmc_pkg::cmd_t      cmd_w, cmd_q;
  kwmc_pkg::out_item_t res_w;
  logic                accept;
  logic                cmd_empty, cmd_pop;
  logic                res_full, res_push;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  kwmc_front #(.MAX_KMER(MAX_KMER)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .accept(accept), .item(in_item), .cmd(cmd_w)
  );

  kwmc_queue #(.T(kwmc_pkg::cmd_t)) u_cmdq (
    .clk(clk), .rst_n(rst_n), .push(in_push), .push_data(cmd_w), .full(in_full),
    .pop(cmd_pop), .pop_data(cmd_q), .empty(cmd_empty)
  );

  kwmc_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_empty(cmd_empty), .cmd_in(cmd_q), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res(res_w)
  );

  kwmc_queue #(.T(kwmc_pkg::out_item_t)) u_resq (
    .clk(clk), .rst_n(rst_n), .push(res_push), .push_data(res_w), .full(res_full),
    .pop(out_pop), .pop_data(out_item), .empty(out_empty)
  );

endmodule

### rtl/kwmc_checker.sv
module kwmc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_push,
  input logic                           in_full,
  input kwmc_pkg::in_item_t             in_item,
  input logic                           out_empty,
  input logic                           out_pop,
  input kwmc_pkg::out_item_t            out_item,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [kwmc_pkg::KLEN_BITS-1:0] cfg_data
);

  // come out of reset with nothing to deliver
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("result waiting right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled result changed");

  // a hit needs a full window, a first mark needs a hit
  a_hit_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((!out_item.hit || out_item.window_valid) &&
                    (!out_item.first_in_record || out_item.hit)))
    else $error("hit flags inconsistent");

  // a base result carries no other kind of report
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.window_valid) |->
      (out_item.load_status == kwmc_pkg::LS_INSERTED &&
       out_item.distinct_hits == '0 && out_item.record_count == '0))
    else $error("base result carries other fields");

endmodule

bind kmer_window_match_counter kwmc_checker u_chk (.*);

### test/kmer_window_match_counter_tb.sv
`timescale 1ns / 100ps

module kmer_window_match_counter_tb;
  import kwmc_pkg::*;

  localparam int NUM_ENTRIES = 4096;
  localparam int IDLE_LIMIT  = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [KLEN_BITS-1:0] cfg_data;

  kmer_window_match_counter dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow of the block's state
  logic [4:0]          klen_reg;
  logic [KEY_BITS-1:0] win_bits;
  int unsigned         run_len;
  logic [KEY_BITS-1:0] lib_keys [NUM_ENTRIES];
  int unsigned         n_loaded;
  logic [31:0]         rec_counts [NUM_ENTRIES];
  bit                  seen [NUM_ENTRIES];
  int unsigned         rec_distinct;

  out_item_t expected_q[$];
  int        fail_count;
  int        idle_cycles;
  bit        no_idle;
  bit        hold_pop;
  int        hold_len;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned window_len();
    int unsigned k;
    k = klen_reg;
    if (k == 0) k = 1;
    if (k > 31) k = 31;
    return k;
  endfunction

  function automatic logic [KEY_BITS-1:0] len_mask(int unsigned k);
    logic [63:0] m;
    m = (64'd1 << (2 * k)) - 64'd1;
    return m[KEY_BITS-1:0];
  endfunction

  function automatic int find_entry(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < n_loaded; i++)
      if (lib_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic int letter_code(logic [7:0] c);
    case (c)
      CH_A_UP, CH_A_LO: return 0;
      CH_C_UP, CH_C_LO: return 1;
      CH_G_UP, CH_G_LO: return 2;
      CH_T_UP, CH_T_LO: return 3;
      default:          return -1;
    endcase
  endfunction

  // Advance the shadow state by one item and return its result
  function automatic out_item_t predict_match(in_item_t it);
    out_item_t r;
    int unsigned k;
    logic [KEY_BITS-1:0] m;
    int pos;
    int code;
    r = '0;
    k = window_len();
    m = len_mask(k);
    case (it.opcode)
      OP_LOAD: begin
        pos = find_entry(it.library_code & m);
        if (pos >= 0) begin
          r.match_index = IDX_BITS'(pos);
          r.load_status = LS_DUPLICATE;
        end else if (n_loaded >= NUM_ENTRIES) begin
          r.load_status = LS_FULL;
        end else begin
          lib_keys[n_loaded] = it.library_code & m;
          rec_counts[n_loaded] = '0;
          r.match_index = IDX_BITS'(n_loaded);
          r.load_status = LS_INSERTED;
          n_loaded++;
        end
      end
      OP_BASE: begin
        code = letter_code(it.base_char);
        if (code < 0) begin
          run_len = 0;
        end else begin
          win_bits = ((win_bits << 2) | KEY_BITS'(code)) & m;
          if (run_len < k) run_len++;
        end
        win_bits &= m;
        if (code >= 0 && run_len >= k) begin
          r.window_valid = 1'b1;
          pos = find_entry(win_bits);
          if (pos >= 0) begin
            r.hit = 1'b1;
            r.match_index = IDX_BITS'(pos);
            if (!seen[pos]) begin
              seen[pos] = 1'b1;
              r.first_in_record = 1'b1;
              if (rec_counts[pos] != 32'hFFFF_FFFF) rec_counts[pos]++;
              if (rec_distinct < 8191) rec_distinct++;
            end
          end
        end
      end
      OP_END: begin
        r.distinct_hits = DIST_BITS'(rec_distinct);
        rec_distinct = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) seen[i] = 1'b0;
        win_bits = '0;
        run_len = 0;
      end
      default: begin
        r.record_count = rec_counts[it.query_index];
      end
    endcase
    return r;
  endfunction

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(0, 99) < 30);
  endfunction

  // Offer one item until its transfer, predicting at acceptance; push stays
  // up afterwards so the next item can follow without a gap
  task automatic send_item(in_item_t it);
    while (take_gap()) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_q = {expected_q, predict_match(it)};
    @(negedge clk);
  endtask

  task automatic send_load(logic [KEY_BITS-1:0] key);
    in_item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.library_code = key;
    send_item(it);
  endtask

  task automatic send_base(logic [7:0] c);
    in_item_t it;
    it = '0;
    it.opcode = OP_BASE;
    it.base_char = c;
    send_item(it);
  endtask

  task automatic send_end();
    in_item_t it;
    it = '0;
    it.opcode = OP_END;
    send_item(it);
  endtask

  task automatic send_count(logic [IDX_BITS-1:0] q);
    in_item_t it;
    it = '0;
    it.opcode = OP_COUNT;
    it.query_index = q;
    send_item(it);
  endtask

  function automatic logic [7:0] letter_of(int code, bit lower);
    logic [7:0] up [4];
    up = '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP};
    return lower ? (up[code] | 8'h20) : up[code];
  endfunction

  // Stream the bases of a packed key, most significant base first
  task automatic send_kmer(logic [KEY_BITS-1:0] key, int unsigned k);
    for (int i = k - 1; i >= 0; i--)
      send_base(letter_of(key[2*i +: 2], $urandom_range(0, 1)));
  endtask

  // Stop offering items and wait until every result is back
  task automatic wait_drained();
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (n_loaded + 20) @(negedge clk);
  endtask

  task automatic write_klen(logic [4:0] v);
    wait_drained();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    klen_reg = v;
    win_bits &= len_mask(window_len());
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed: extremes, every op, bad bases, short reads, length zero
  task automatic test_directed();
    send_count(12'd0);
    send_load({KEY_BITS{1'b1}});
    send_load({KEY_BITS{1'b1}});
    send_load('0);
    send_kmer({KEY_BITS{1'b1}}, 31);
    send_kmer({KEY_BITS{1'b1}}, 1);
    send_end();
    send_count(12'd0);
    send_count(12'hFFF);
    write_klen(5'd0);
    send_load(62'h2);
    send_base(CH_G_LO);
    send_base(8'h00);
    send_base(8'hFF);
    send_base(CH_T_UP);
    send_end();
    write_klen(5'd3);
    send_load(62'h3F_FFFF);
    send_base(CH_T_LO);
    send_base(CH_T_UP);
    send_end();
    send_base(CH_T_UP);
    send_base(8'h4E);
    send_base(CH_T_UP);
    send_base(CH_T_UP);
    send_base(CH_T_UP);
    send_end();
  endtask

  // Random records built mostly from library k-mers, with noise between them
  task automatic test_random(int n_items);
    int sent;
    int sel;
    int unsigned k;
    logic [KEY_BITS-1:0] key;
    sent = 0;
    while (sent < n_items) begin
      k = window_len();
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        key = KEY_BITS'({$urandom, $urandom}) & len_mask(k);
        if ($urandom_range(0, 3) == 0) key = KEY_BITS'({$urandom, $urandom});
        send_load(key);
        sent++;
      end else if (sel < 55 && n_loaded != 0) begin
        send_kmer(lib_keys[$urandom_range(0, n_loaded - 1)], k);
        sent += k;
      end else if (sel < 80) begin
        if ($urandom_range(0, 4) == 0) send_base(8'($urandom));
        else send_base(letter_of($urandom_range(0, 3), $urandom_range(0, 1)));
        sent++;
      end else if (sel < 90) begin
        send_end();
        sent++;
      end else begin
        if (n_loaded != 0 && $urandom_range(0, 3) != 0)
          send_count(IDX_BITS'($urandom_range(0, n_loaded - 1)));
        else
          send_count(IDX_BITS'($urandom_range(0, 4095)));
        sent++;
      end
    end
  endtask

  // Hold the receiver off so the block backs up, then drain
  task automatic test_backpressure();
    hold_len = 300;
    hold_pop = 1'b1;
    for (int i = 0; i < 20; i++) send_count(IDX_BITS'($urandom_range(0, 4095)));
    wait_drained();
  endtask

  // Load single-bit keys spread across the key width, with a base and a count after each
  task automatic test_bit_toggle();
    for (int b = 0; b < KEY_BITS; b += 7) begin
      send_load(62'd1 << b);
      send_base(8'd1 << (b % 8));
      send_count(12'd1 << (b % 12));
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_item.window_valid !== exp_r.window_valid) begin
          $error("window_valid exp %0d got %0d", exp_r.window_valid, out_item.window_valid);
          fail_count++;
        end
        if (out_item.hit !== exp_r.hit) begin
          $error("hit exp %0d got %0d", exp_r.hit, out_item.hit);
          fail_count++;
        end
        if (out_item.first_in_record !== exp_r.first_in_record) begin
          $error("first_in_record exp %0d got %0d", exp_r.first_in_record,
                 out_item.first_in_record);
          fail_count++;
        end
        if (out_item.match_index !== exp_r.match_index) begin
          $error("match_index exp %0d got %0d", exp_r.match_index, out_item.match_index);
          fail_count++;
        end
        if (out_item.load_status !== exp_r.load_status) begin
          $error("load_status exp %0d got %0d", exp_r.load_status, out_item.load_status);
          fail_count++;
        end
        if (out_item.distinct_hits !== exp_r.distinct_hits) begin
          $error("distinct_hits exp %0d got %0d", exp_r.distinct_hits,
                 out_item.distinct_hits);
          fail_count++;
        end
        if (out_item.record_count !== exp_r.record_count) begin
          $error("record_count exp %0d got %0d", exp_r.record_count, out_item.record_count);
          fail_count++;
        end
      end
    end
  end

  // Drive pop with random stalls and an occasional long hold
  always @(negedge clk) begin
    if (hold_pop) begin
      out_pop <= 1'b0;
      hold_len--;
      if (hold_len <= 0) hold_pop = 1'b0;
    end else begin
      out_pop <= !take_gap();
    end
  end

  // Stop the run if nothing transfers for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    hold_pop = 1'b0;
    hold_len = 0;
    klen_reg = 5'd31;
    win_bits = '0;
    run_len = 0;
    n_loaded = 0;
    rec_distinct = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      rec_counts[i] = '0;
      seen[i] = 1'b0;
      lib_keys[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_bit_toggle();
    test_backpressure();
    write_klen(5'd31);
    test_random(400);
    write_klen(5'd5);
    no_idle = 1'b1;
    test_random(300);
    no_idle = 1'b0;
    write_klen(5'd1);
    test_random(200);
    write_klen(5'd12);
    test_random(550);
    wait_drained();

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
